### rtl/cpr_pkg.sv
// Package for the case preserving replace block: item, configuration and job types,
// register indexes and the letter helper functions. No dependencies.
`default_nettype none

package cpr_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned PosW       = $clog2(MaxPattern);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharUpZ = 8'h5a;
  localparam logic [7:0] CharLoA = 8'h61;
  localparam logic [7:0] CharLoZ = 8'h7a;
  localparam logic [7:0] CaseGap = CharLoA - CharUpA;

  typedef enum logic [CfgIdxW-1:0] {
    RegFindText     = 2'd0,
    RegFindLength   = 2'd1,
    RegReplaceText  = 2'd2,
    RegReplaceLength = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] find_text;
    logic [LenW-1:0]            find_length;
    logic [MaxPattern-1:0][7:0] replace_text;
    logic [LenW-1:0]            replace_length;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic [LenW-1:0] value;
  } len_upd_t;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] bytes;
    logic [LenW-1:0]            count;
  } job_t;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= CharUpA) && (c <= CharUpZ);
  endfunction

  function automatic logic is_lo(input logic [7:0] c);
    return (c >= CharLoA) && (c <= CharLoZ);
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return is_lo(c) ? c - CaseGap : c;
  endfunction

  function automatic logic [7:0] to_lo(input logic [7:0] c);
    return is_up(c) ? c + CaseGap : c;
  endfunction

  function automatic logic same_letter(input logic [7:0] a, input logic [7:0] b);
    return (a == b) || ((is_up(a) || is_lo(a)) && ((a ^ CaseGap) == b));
  endfunction

  function automatic logic [LenW-1:0] eff_find_len(input logic [LenW-1:0] l);
    logic [LenW-1:0] r;
    r = l;
    if (r == '0) r = LenW'(1);
    if (r > LenW'(MaxPattern)) r = LenW'(MaxPattern);
    return r;
  endfunction

  function automatic logic [LenW-1:0] eff_rep_len(input logic [LenW-1:0] l);
    return (l > LenW'(MaxPattern)) ? LenW'(MaxPattern) : l;
  endfunction

endpackage

`default_nettype wire

### rtl/cpr_front.sv
// Front end: holds the byte window, compares it with the find pattern and turns each
// accepted byte into at most one job of output bytes. Depends on cpr_pkg.
`default_nettype none

module cpr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cpr_pkg::cfg_t   cfg_i,
  input  wire cpr_pkg::len_upd_t len_upd_i,
  input  wire logic            accept_i,
  input  wire cpr_pkg::in_item_t item_i,
  output logic                 push_o,
  output cpr_pkg::job_t        job_o
);
  import cpr_pkg::*;

  logic [MaxPattern-1:0][7:0] window_q, window_d;
  logic [LenW-1:0]            fill_q, fill_d;

  logic [MaxPattern-1:0][7:0] w, ws, adapted;
  logic [LenW-1:0]            len, fill0, fill1, rep_len;
  logic                       full_win, match, hit, first_up, later_up, up;

  always_comb begin
    len   = eff_find_len(cfg_i.find_length);
    fill0 = (fill_q >= len) ? '0 : fill_q;
    fill1 = fill0 + LenW'(1);
    for (int i = 0; i < MaxPattern; i++) begin
      w[i] = (fill0 == LenW'(i)) ? item_i.in_byte : window_q[i];
    end
    for (int i = 0; i < MaxPattern; i++) begin
      ws[i] = (i < MaxPattern - 1) ? w[(i + 1) % MaxPattern] : w[i];
    end
    full_win = (fill1 == len);
    match    = 1'b1;
    later_up = 1'b0;
    for (int i = 0; i < MaxPattern; i++) begin
      if (LenW'(i) < len && !same_letter(w[i], cfg_i.find_text[i])) match = 1'b0;
      if (i > 0 && LenW'(i) < len && is_up(w[i])) later_up = 1'b1;
    end
    first_up = is_up(w[0]);
    hit      = full_win && match;
    rep_len  = eff_rep_len(cfg_i.replace_length);
    for (int i = 0; i < MaxPattern; i++) begin
      up         = (i == 0) ? first_up : (first_up && later_up);
      adapted[i] = up ? to_up(cfg_i.replace_text[i]) : to_lo(cfg_i.replace_text[i]);
    end

    // Flushed bytes always follow the window order, with or without a leading byte.
    if (hit) begin
      job_o.bytes = adapted;
      job_o.count = rep_len;
    end else if (item_i.is_final) begin
      job_o.bytes = w;
      job_o.count = fill1;
    end else begin
      job_o.bytes = w;
      job_o.count = full_win ? LenW'(1) : '0;
    end
    push_o = accept_i && (job_o.count != '0);

    window_d = window_q;
    fill_d   = fill_q;
    if (accept_i) begin
      if (hit || item_i.is_final) begin
        window_d = w;
        fill_d   = '0;
      end else if (full_win) begin
        window_d = ws;
        fill_d   = fill1 - LenW'(1);
      end else begin
        window_d = w;
        fill_d   = fill1;
      end
    end else if (len_upd_i.we && fill_q >= eff_find_len(len_upd_i.value)) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cpr_queue.sv
// Short job queue between the front and back ends, first in first out.
// Depends on cpr_pkg.
`default_nettype none

module cpr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cpr_pkg::job_t job_i,
  input  wire logic          pop_i,
  output cpr_pkg::job_t      head_o,
  output logic               not_empty_o,
  output logic               full_o
);
  import cpr_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]       cnt_q;

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign full_o      = (cnt_q == (QPtrW + 1)'(QueueDepth));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (QPtrW + 1)'(push_i) - (QPtrW + 1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

### rtl/cpr_back.sv
// Back end: sends the bytes of the job at the queue head one per cycle, while the output
// is not held off, through an output register. Depends on cpr_pkg.
`default_nettype none

module cpr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cpr_pkg::job_t head_i,
  input  wire logic          not_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cpr_pkg::out_item_t out_item_o
);
  import cpr_pkg::*;

  logic [PosW-1:0] idx_q, idx_d;
  logic            valid_q;
  out_item_t       item_q;
  logic            load, last;

  always_comb begin
    load  = not_empty_i && (!valid_q || out_ready_i);
    last  = ({1'b0, idx_q} == head_i.count - LenW'(1));
    pop_o = load && last;
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.out_byte <= head_i.bytes[idx_q];
      item_q.run_last <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### rtl/case_preserving_replace.sv
// Top level of the case preserving replace block: configuration registers, front end,
// job queue and back end. Depends on cpr_pkg, cpr_front, cpr_queue and cpr_back.
//
// The block takes one text byte per cycle while its two-entry job queue has room, and
// sends one result byte per cycle while the output accepts. Each input byte yields at
// most one job: a match emits the case-adapted replacement (up to eight bytes), else the
// oldest window byte once the window is full, and a final byte adds the rest of the
// window. A job of n bytes holds the single output port until all are sent, so input
// stalls while multi-byte jobs drain or the output is held off. The user must write
// configuration via the plain write port only while idle; the block does not enforce it.
`default_nettype none

module case_preserving_replace (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cpr_pkg::in_item_t             in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output cpr_pkg::out_item_t                 out_item_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [8*cpr_pkg::MaxPattern-1:0] cfg_data_i
);
  import cpr_pkg::*;

  cfg_t     cfg_q;
  len_upd_t len_upd;
  job_t     job, head;
  logic     accept, push, pop, not_empty, full;

  assign in_ready_o    = !full;
  assign accept        = in_valid_i && !full;
  assign len_upd.we    = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == RegFindLength);
  assign len_upd.value = cfg_data_i[LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.find_text      <= '0;
      cfg_q.find_length    <= LenW'(1);
      cfg_q.replace_text   <= '0;
      cfg_q.replace_length <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegFindText:      cfg_q.find_text      <= cfg_data_i;
        RegFindLength:    cfg_q.find_length    <= cfg_data_i[LenW-1:0];
        RegReplaceText:   cfg_q.replace_text   <= cfg_data_i;
        RegReplaceLength: cfg_q.replace_length <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  cpr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .len_upd_i (len_upd),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .push_o    (push),
    .job_o     (job)
  );

  cpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  cpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .not_empty_i (not_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### tb/sv/tb_case_preserving_replace.sv
// Testbench for case_preserving_replace: streams text bytes under several pattern settings
// and idle mixes, and checks every output word against a scoreboard with its own predictor.
// Depends on cpr_pkg and the case_preserving_replace RTL.
`default_nettype none

module tb_case_preserving_replace;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseWords   = 46;

  class text_replace_sb;
    logic [63:0] find_pat;
    logic [3:0]  find_len;
    logic [63:0] repl_pat;
    logic [3:0]  repl_len;
    logic [7:0]  window [MaxPattern];
    int unsigned fill;
    out_item_t   expected_words [$];
    int unsigned errors;

    function new();
      find_pat = '0;
      find_len = 4'd1;
      repl_pat = '0;
      repl_len = '0;
      fill     = 0;
      errors   = 0;
      foreach (window[i]) window[i] = 8'h00;
    endfunction

    function bit upper(logic [7:0] c);
      return c >= CharUpA && c <= CharUpZ;
    endfunction

    function bit lower(logic [7:0] c);
      return c >= CharLoA && c <= CharLoZ;
    endfunction

    function logic [7:0] raise(logic [7:0] c);
      return lower(c) ? c - CaseGap : c;
    endfunction

    function logic [7:0] drop_case(logic [7:0] c);
      return upper(c) ? c + CaseGap : c;
    endfunction

    function bit same_char(logic [7:0] a, logic [7:0] b);
      return a == b || (lower(a) && a - CaseGap == b) || (upper(a) && a + CaseGap == b);
    endfunction

    function int unsigned find_span();
      if (find_len == 4'd0) return 1;
      if (find_len > 4'(MaxPattern)) return MaxPattern;
      return find_len;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        RegFindText: find_pat = data;
        RegFindLength: begin
          find_len = data[3:0];
          if (fill >= find_span()) fill = 0;
        end
        RegReplaceText: repl_pat = data;
        RegReplaceLength: repl_len = data[3:0];
        default: ;
      endcase
    endfunction

    function void note_word(in_item_t w);
      logic [7:0]  outs [$];
      int unsigned span;
      int unsigned rspan;
      bit          hit;
      bit          first_up;
      bit          later_up;
      logic [7:0]  c;
      span = find_span();
      if (fill >= span) fill = 0;
      window[fill] = w.in_byte;
      fill++;
      if (fill == span) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++)
          if (!same_char(window[i], find_pat[8*i +: 8])) hit = 1'b0;
        if (hit) begin
          first_up = upper(window[0]);
          later_up = 1'b0;
          for (int i = 1; i < span; i++)
            if (upper(window[i])) later_up = 1'b1;
          rspan = (repl_len > 4'(MaxPattern)) ? MaxPattern : repl_len;
          for (int i = 0; i < rspan; i++) begin
            c = repl_pat[8*i +: 8];
            if ((i == 0) ? first_up : (first_up && later_up)) outs.push_back(raise(c));
            else outs.push_back(drop_case(c));
          end
          fill = 0;
        end else begin
          outs.push_back(window[0]);
          for (int i = 1; i < fill; i++) window[i-1] = window[i];
          fill--;
        end
      end
      if (w.is_final) begin
        for (int i = 0; i < fill; i++) outs.push_back(window[i]);
        fill = 0;
      end
      foreach (outs[i])
        expected_words.push_back('{out_byte: outs[i], run_last: (i == outs.size() - 1)});
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual out_byte %h run_last %b",
                 $time, got.out_byte, got.run_last);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
      end
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  in_item_t                    in_item_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  out_item_t                   out_item_o;
  logic                        cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]          cfg_idx_i   = '0;
  logic [8*MaxPattern-1:0]     cfg_data_i  = '0;
  int unsigned                 send_idle   = 0;
  int unsigned                 recv_stall  = 0;
  text_replace_sb              sb;

  case_preserving_replace dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_word(out_item_o);
    end
  end

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '{in_byte: 8'($urandom), is_final: 1'($urandom)};
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit final_last);
    for (int i = 0; i < s.len(); i++)
      send_word('{in_byte: s[i], is_final: final_last && (i == s.len() - 1)});
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_patterns(input logic [63:0] find, input logic [3:0] flen,
                              input logic [63:0] repl, input logic [3:0] rlen);
    write_reg(RegFindText, find);
    write_reg(RegFindLength, {$urandom, 28'($urandom), flen});
    write_reg(RegReplaceText, repl);
    write_reg(RegReplaceLength, {$urandom, 28'($urandom), rlen});
  endtask

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] b;
    b = CharUpA + 8'($urandom_range(25));
    return $urandom_range(1) ? b + CaseGap : b;
  endfunction

  function automatic logic [63:0] random_pattern();
    logic [63:0] v;
    for (int i = 0; i < 8; i++)
      v[8*i +: 8] = ($urandom_range(99) < 70) ? random_letter() : 8'($urandom);
    return v;
  endfunction

  // Mostly whole pattern occurrences with random letter case, some cut-off
  // prefixes, and the rest free noise; finals fall anywhere.
  task automatic send_stream(input int unsigned count);
    int unsigned sent;
    int unsigned span;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    logic [7:0]  chunk [$];
    sent = 0;
    while (sent < count) begin
      chunk.delete();
      span = sb.find_span();
      pick = $urandom_range(99);
      n = (pick < 55) ? span : (pick < 70) ? $urandom_range(span - 1) : 0;
      for (int i = 0; i < n; i++) begin
        b = sb.find_pat[8*i +: 8];
        if ((sb.upper(b) || sb.lower(b)) && $urandom_range(1)) b = b ^ CaseGap;
        chunk.push_back(b);
      end
      if (n == 0)
        repeat ($urandom_range(4, 1))
          chunk.push_back($urandom_range(1) ? 8'($urandom) : random_letter());
      foreach (chunk[i]) begin
        send_word('{in_byte: chunk[i], is_final: ($urandom_range(99) < 4)});
        sent++;
      end
    end
  endtask

  initial begin
    logic [63:0] find;
    logic [63:0] repl;
    logic [3:0]  flen;
    logic [3:0]  rlen;
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_patterns(pack_text("cat"), 4'd3, pack_text("dog1"), 4'd4);
    send_text("CatCATcAT", 1'b0);
    send_word('{in_byte: 8'h00, is_final: 1'b0});
    send_word('{in_byte: 8'hff, is_final: 1'b0});
    send_word('{in_byte: 8'h7f, is_final: 1'b1});
    settle();

    // Pending window bytes are dropped when the find length shrinks to them.
    write_reg(RegFindLength, {$urandom, 28'($urandom), 4'd8});
    send_text("xyz", 1'b0);
    settle();
    write_reg(RegFindLength, 64'd0);
    write_reg(RegFindText, pack_text("@"));
    write_reg(RegReplaceLength, 64'd0);
    send_text("@`{", 1'b1);
    settle();

    set_patterns(pack_text("Quick@[{"), 4'd15, pack_text("aBcDeFgH"), 4'd12);
    send_text("qUICK@[{", 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      flen = (p == 0) ? 4'd1 : (p == 1) ? 4'd8 : (p == 2) ? 4'd0 : (p == 3) ? 4'd15 :
             4'($urandom_range(15));
      rlen = (p == 0) ? 4'd8 : (p == 1) ? 4'd0 : (p == 2) ? 4'd15 : (p == 3) ? 4'd1 :
             4'($urandom_range(15));
      find = (p == 5) ? '1 : random_pattern();
      repl = (p == 6) ? '1 : (p == 7) ? '0 : {$urandom, $urandom};
      set_patterns(find, flen, repl, rlen);
      send_stream(PhaseWords);
      settle();
    end

    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
